@@ rtl/pcc_pkg.sv @@
// Shared types, constants and color rom for the palette color cycler.
package pcc_pkg;

  localparam int unsigned NumGroups = 4;
  localparam int unsigned NumRings  = 5;
  localparam int unsigned NumSegs   = 6;
  localparam int unsigned QDepth    = 2;

  localparam logic [7:0] PeriodSlow     = 8'd200;
  localparam logic [7:0] PeriodMedium   = 8'd142;
  localparam logic [7:0] PeriodFast     = 8'd100;
  localparam logic [7:0] PeriodVeryFast = 8'd33;

  localparam logic [5:0] PulseTop  = 6'd60;
  localparam logic [5:0] PulseStep = 6'd4;

  // group bit positions in a tick command
  localparam int unsigned GrpSlow     = 0;
  localparam int unsigned GrpMedium   = 1;
  localparam int unsigned GrpFast     = 2;
  localparam int unsigned GrpVeryFast = 3;

  // configuration register indexes
  localparam logic RegSpeed  = 1'b0;
  localparam logic RegEnable = 1'b1;

  // write segments in emission order
  localparam logic [2:0] SegGreen  = 3'd0;
  localparam logic [2:0] SegShore  = 3'd1;
  localparam logic [2:0] SegSlowFi = 3'd2;
  localparam logic [2:0] SegFastFi = 3'd3;
  localparam logic [2:0] SegScreen = 3'd4;
  localparam logic [2:0] SegPulse  = 3'd5;

  typedef struct packed {
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
  } rgb_t;

  // one fired tick: which groups are due
  typedef struct packed {
    logic                 valid;
    logic [NumGroups-1:0] due;
  } tick_cmd_t;

  function automatic logic [7:0] group_period(input logic [1:0] grp);
    logic [7:0] p;
    unique case (grp)
      2'd0:    p = PeriodSlow;
      2'd1:    p = PeriodMedium;
      2'd2:    p = PeriodFast;
      default: p = PeriodVeryFast;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] seg_len(input logic [2:0] seg);
    logic [2:0] l;
    unique case (seg)
      SegGreen:  l = 3'd4;
      SegShore:  l = 3'd6;
      SegSlowFi: l = 3'd5;
      SegFastFi: l = 3'd5;
      SegScreen: l = 3'd5;
      default:   l = 3'd1;
    endcase
    return l;
  endfunction

  function automatic logic [4:0] seg_base(input logic [2:0] seg);
    logic [4:0] b;
    unique case (seg)
      SegGreen:  b = 5'd0;
      SegShore:  b = 5'd4;
      SegSlowFi: b = 5'd10;
      SegFastFi: b = 5'd15;
      SegScreen: b = 5'd20;
      default:   b = 5'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] seg_entry(input logic [2:0] seg);
    logic [7:0] e;
    unique case (seg)
      SegGreen:  e = 8'd229;
      SegShore:  e = 8'd248;
      SegSlowFi: e = 8'd238;
      SegFastFi: e = 8'd243;
      SegScreen: e = 8'd233;
      default:   e = 8'd254;
    endcase
    return e;
  endfunction

  function automatic rgb_t color_rom(input logic [4:0] idx);
    rgb_t c;
    unique case (idx)
      5'd0:    c = '{6'd0,  6'd27, 6'd0};
      5'd1:    c = '{6'd2,  6'd28, 6'd1};
      5'd2:    c = '{6'd6,  6'd30, 6'd3};
      5'd3:    c = '{6'd10, 6'd32, 6'd6};
      5'd4:    c = '{6'd20, 6'd15, 6'd10};
      5'd5:    c = '{6'd18, 6'd14, 6'd10};
      5'd6:    c = '{6'd16, 6'd13, 6'd9};
      5'd7:    c = '{6'd15, 6'd12, 6'd9};
      5'd8:    c = '{6'd13, 6'd11, 6'd8};
      5'd9:    c = '{6'd12, 6'd10, 6'd8};
      5'd10:   c = '{6'd63, 6'd0,  6'd0};
      5'd11:   c = '{6'd53, 6'd0,  6'd0};
      5'd12:   c = '{6'd36, 6'd10, 6'd2};
      5'd13:   c = '{6'd63, 6'd29, 6'd0};
      5'd14:   c = '{6'd63, 6'd14, 6'd0};
      5'd15:   c = '{6'd17, 6'd0,  6'd0};
      5'd16:   c = '{6'd30, 6'd0,  6'd0};
      5'd17:   c = '{6'd44, 6'd0,  6'd0};
      5'd18:   c = '{6'd30, 6'd0,  6'd0};
      5'd19:   c = '{6'd17, 6'd0,  6'd0};
      5'd20:   c = '{6'd26, 6'd26, 6'd27};
      5'd21:   c = '{6'd24, 6'd25, 6'd31};
      5'd22:   c = '{6'd21, 6'd26, 6'd35};
      5'd23:   c = '{6'd0,  6'd36, 6'd40};
      5'd24:   c = '{6'd26, 6'd46, 6'd63};
      default: c = '{6'd0,  6'd0,  6'd0};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/palette_color_cycler.sv @@
// Top level of the palette color cycler: config registers, front, queue, back.
//
//  channel  dir  handshake                   payload
//  ticks    in   in_valid_i / in_stall_o     now_ms_i
//  writes   out  out_valid_o / out_stall_i   entry_index_o, red/green/blue_level_o,
//                                            final_write_o
//  config   in   cfg_we_i                    cfg_idx_i, cfg_data_i
//
// The front takes one tick per cycle while the two-entry command queue has room.
// The back loads a command, then makes one write per entry of each due segment
// (up to 26 in all) and steps over each segment that is not due.
// Reset clears stamps, ring offsets, pulse state and queue; speed is 1, cycling on.
// out_stall_i holds the output register and the walk while a write waits; the queue
// fills, then in_stall_o rises.
module palette_color_cycler import pcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  entry_index_o,
  output logic [5:0]  red_level_o,
  output logic [5:0]  green_level_o,
  output logic [5:0]  blue_level_o,
  output logic        final_write_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]           speed_q;
  logic                 enable_q;
  tick_cmd_t            cmd;
  logic                 q_full, q_valid, q_pop;
  logic [NumGroups-1:0] q_due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= 8'd1;
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSpeed:  speed_q  <= cfg_data_i;
        RegEnable: enable_q <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  pcc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .now_ms_i          (now_ms_i),
    .speed_factor_i    (speed_q),
    .cycling_enabled_i (enable_q),
    .q_full_i          (q_full),
    .cmd_o             (cmd)
  );

  pcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .due_o   (q_due),
    .pop_i   (q_pop)
  );

  pcc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_due_i       (q_due),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_index_o (entry_index_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .final_write_o (final_write_o)
  );

endmodule

@@ rtl/pcc_front.sv @@
// Tick front end: keeps group stamps, decides which groups fire.
module pcc_front import pcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  speed_factor_i,
  input  logic        cycling_enabled_i,
  input  logic        q_full_i,
  output tick_cmd_t   cmd_o
);

  logic [31:0]          stamp_q [NumGroups];
  logic [NumGroups-1:0] due;
  logic                 accept;

  always_comb begin
    logic [15:0] need;
    logic [31:0] elapsed;
    due = '0;
    for (int g = 0; g < NumGroups; g++) begin
      need    = {8'd0, group_period(2'(g))} * {8'd0, speed_factor_i};
      elapsed = now_ms_i - stamp_q[g];
      // a stamp ahead of now counts as long overdue
      due[g]  = (stamp_q[g] > now_ms_i) || (elapsed >= {16'd0, need});
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign cmd_o.valid = accept && cycling_enabled_i && (|due);
  assign cmd_o.due   = due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NumGroups; g++) stamp_q[g] <= '0;
    end else if (accept && cycling_enabled_i) begin
      for (int g = 0; g < NumGroups; g++) begin
        if (due[g]) stamp_q[g] <= now_ms_i;
      end
    end
  end

endmodule

@@ rtl/pcc_queue.sv @@
// Two-entry queue of fired tick commands between front and back.
module pcc_queue import pcc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tick_cmd_t            push_i,
  output logic                 full_o,
  output logic                 valid_o,
  output logic [NumGroups-1:0] due_o,
  input  logic                 pop_i
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic [NumGroups-1:0] slot_q [QDepth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign due_o   = slot_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_i.due;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o) else $error("push into full queue");
  a_cmd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (push_i.due != '0)) else $error("empty tick command queued");
`endif

endmodule

@@ rtl/pcc_back.sv @@
// Back end: walks the due groups and emits palette entry writes.
module pcc_back import pcc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic [NumGroups-1:0] q_due_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           entry_index_o,
  output logic [5:0]           red_level_o,
  output logic [5:0]           green_level_o,
  output logic [5:0]           blue_level_o,
  output logic                 final_write_o
);

  logic                 active_q;
  logic [NumGroups-1:0] due_q;
  logic [2:0]           seg_q, k_q;
  logic [2:0]           off_q [NumRings];
  logic [5:0]           pulse_level_q;
  logic                 pulse_rising_q;

  logic                 out_valid_q, final_q;
  logic [7:0]           entry_q;
  rgb_t                 rgb_q;

  logic [NumSegs-1:0]   seg_en, later_mask;
  logic                 cur_en, later, last_k, step, emit;
  logic [2:0]           len, off;
  logic [3:0]           sum;
  logic [4:0]           idx;
  logic                 rise_n;
  logic [5:0]           level_n;
  rgb_t                 rgb;

  assign seg_en = {due_q[GrpVeryFast], due_q[GrpFast], due_q[GrpMedium],
                   due_q[GrpSlow], due_q[GrpSlow], due_q[GrpSlow]};

  always_comb begin
    for (int i = 0; i < NumSegs; i++) later_mask[i] = (3'(i) > seg_q);
  end

  assign cur_en = seg_en[seg_q];
  assign later  = |(seg_en & later_mask);
  assign len    = seg_len(seg_q);
  assign last_k = (k_q == len - 3'd1);
  // skipped segments do not need output space
  assign step   = active_q && (!cur_en || !out_valid_q || !out_stall_i);
  assign emit   = step && cur_en;

  assign q_pop_o = !active_q && q_valid_i;

  // ring color: (offset + k) mod len, both below len
  assign off = (seg_q == SegPulse) ? 3'd0 : off_q[seg_q];
  always_comb begin
    sum = {1'b0, off} + {1'b0, k_q};
    if (sum >= {1'b0, len}) sum = sum - {1'b0, len};
    idx = seg_base(seg_q) + {1'b0, sum};
  end

  // triangle wave: flip direction at either end, then move one step
  assign rise_n  = (pulse_level_q == 6'd0 || pulse_level_q == PulseTop) ?
                   !pulse_rising_q : pulse_rising_q;
  assign level_n = rise_n ? pulse_level_q + PulseStep : pulse_level_q - PulseStep;

  always_comb begin
    if (seg_q == SegPulse) rgb = '{level_n, 6'd0, 6'd0};
    else                   rgb = color_rom(idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      seg_q          <= SegGreen;
      k_q            <= '0;
      pulse_level_q  <= '0;
      pulse_rising_q <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int r = 0; r < NumRings; r++) off_q[r] <= '0;
    end else begin
      if (q_pop_o) begin
        active_q <= 1'b1;
        seg_q    <= SegGreen;
        k_q      <= '0;
      end else if (step) begin
        if (!cur_en || last_k) begin
          if ((cur_en && !later) || seg_q == SegPulse) active_q <= 1'b0;
          else seg_q <= seg_q + 3'd1;
          k_q <= '0;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end

      if (emit && last_k) begin
        if (seg_q == SegPulse) begin
          pulse_level_q  <= level_n;
          pulse_rising_q <= rise_n;
        end else begin
          off_q[seg_q] <= (off == 3'd0) ? len - 3'd1 : off - 3'd1;
        end
      end

      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) due_q <= q_due_i;
    if (emit) begin
      entry_q <= seg_entry(seg_q) + {5'd0, k_q};
      rgb_q   <= rgb;
      final_q <= last_k && !later;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = entry_q;
  assign red_level_o   = rgb_q.r;
  assign green_level_o = rgb_q.g;
  assign blue_level_o  = rgb_q.b;
  assign final_write_o = final_q;

`ifndef SYNTH
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (seg_q <= SegPulse)) else $error("segment out of range");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (k_q < seg_len(seg_q))) else $error("ring position out of range");
  a_pulse_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pulse_level_q[1:0] == 2'b00) && (pulse_level_q <= PulseTop))
    else $error("pulse level off grid");
  a_done_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_k && !later) |=> !active_q) else $error("walk continued past final write");
`endif

endmodule
